@@ rtl/psfa_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psfa_pkg
// Shared constants and types of the particle sensor frame averager: frame
// marker bytes, channel count, default sizes and the structs that travel
// between the frame parser, the divider and the top level.
// ----------------------------------------------------------------------------
package psfa_pkg;

  // Frame marker bytes.
  localparam logic [7:0] START_BYTE  = 8'h42;
  localparam logic [7:0] SECOND_BYTE = 8'h4d;

  // Particle size channels: PM1.0, PM2.5 and PM10.
  localparam int CHANNELS = 3;
  localparam logic [1:0] CH_LAST = 2'd2;

  // Field widths.
  localparam int WORD_W = 16;
  localparam int HELD_W = 5;

  // Default sizes.
  localparam int FRAME_BYTES_DEF = 31;
  localparam int WINDOW_DEF      = 16;

  typedef logic [WORD_W-1:0] word_t;

  // A good frame has arrived; the three PM words it carried.
  typedef struct packed {
    logic                       valid;
    logic [CHANNELS-1:0][WORD_W-1:0] pm;
  } frame_t;

  // Divider status.
  typedef struct packed {
    logic busy;
    logic done;
  } div_status_t;

endpackage : psfa_pkg
`default_nettype wire

@@ rtl/psfa_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psfa_if
// Valid/ready channels of the averager: serial bytes in, one result beat
// per good frame out.
// ----------------------------------------------------------------------------
interface psfa_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink (input valid, input rx_byte, output ready);
endinterface : psfa_byte_if

interface psfa_result_if;
  logic        valid;
  logic        ready;
  logic [15:0] pm1_raw;
  logic [15:0] pm25_raw;
  logic [15:0] pm10_raw;
  logic [15:0] pm1_average;
  logic [15:0] pm25_average;
  logic [15:0] pm10_average;
  logic [4:0]  samples_held;

  modport source (
    output valid, output pm1_raw, output pm25_raw, output pm10_raw,
    output pm1_average, output pm25_average, output pm10_average,
    output samples_held, input ready
  );
  modport sink (
    input valid, input pm1_raw, input pm25_raw, input pm10_raw,
    input pm1_average, input pm25_average, input pm10_average,
    input samples_held, output ready
  );
endinterface : psfa_result_if
`default_nettype wire

@@ rtl/psfa_ram.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psfa_ram
// Generic simple dual-port RAM: one write port, one read port with a
// registered read.
// ----------------------------------------------------------------------------
module psfa_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 48
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port.
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule : psfa_ram
`default_nettype wire

@@ rtl/psfa_div.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psfa_div
// Iterative restoring divider for unsigned integers. One quotient bit per
// cycle.
// ----------------------------------------------------------------------------
module psfa_div
  import psfa_pkg::*;
#(
  parameter int W  = 20,
  parameter int DW = 5
) (
  input  wire logic          clk,
  input  wire logic          rst,
  input  wire logic          start,
  input  wire logic [W-1:0]  dividend,
  input  wire logic [DW-1:0] divisor,
  output logic      [W-1:0]  quotient,
  output div_status_t        status
);

  localparam int CW = $clog2(W + 1);

  logic [DW:0]   rem;
  logic [W-1:0]  quo;
  logic [DW-1:0] dvs;
  logic [CW-1:0] cnt;
  logic          busy;
  logic          done;
  logic [DW:0]   trial;
  logic          fits;

  // Shift in the next dividend bit and test the divisor against it.
  assign trial = {rem[DW-1:0], quo[W-1]};
  assign fits  = (trial >= {1'b0, dvs});

  // Control: busy while the W quotient bits are formed, then a one-cycle done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: remainder and the shift register that turns dividend into
  // quotient.
  always_ff @(posedge clk) begin
    if (start) begin
      rem <= '0;
      quo <= dividend;
      dvs <= divisor;
    end else if (busy) begin
      rem <= fits ? (trial - {1'b0, dvs}) : trial;
      quo <= {quo[W-2:0], fits};
    end
  end

  assign quotient    = quo;
  assign status.busy = busy;
  assign status.done = done;

endmodule : psfa_div
`default_nettype wire

@@ rtl/psfa_frame.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// psfa_frame
// Frame parser: hunts for the start byte, collects a fixed-length frame,
// checks the second byte and the checksum trailer, and reports the PM words
// of every good frame with a one-cycle pulse.
// ----------------------------------------------------------------------------
module psfa_frame
  import psfa_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
) (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       beat,
  input  wire logic [7:0] data,
  output frame_t          frame
);

  localparam int POSW = $clog2(FRAME_BYTES);

  logic                            collecting;
  logic [POSW-1:0]                 pos;
  word_t                           csum;
  logic                            second_ok;
  logic [CHANNELS-1:0][WORD_W-1:0] words;
  logic [7:0]                      trail_hi;
  logic                            last;
  logic                            good;
  logic                            frame_valid;
  logic [CHANNELS-1:0][WORD_W-1:0] frame_pm;

  assign last = (pos == POSW'(FRAME_BYTES - 1));
  assign good = second_ok && (csum == {trail_hi, data});

  // The frame report is built from the pulse and the held PM words.
  assign frame = {frame_valid, frame_pm};

  // Frame control and the pulse for a good frame.
  always_ff @(posedge clk) begin
    if (rst) begin
      collecting  <= 1'b0;
      pos         <= '0;
      frame_valid <= 1'b0;
    end else begin
      frame_valid <= 1'b0;
      if (beat) begin
        if (!collecting) begin
          if (data == START_BYTE) begin
            collecting <= 1'b1;
            pos        <= '0;
          end
        end else if (last) begin
          collecting  <= 1'b0;
          pos         <= '0;
          frame_valid <= good;
        end else begin
          pos <= pos + 1'b1;
        end
      end
    end
  end

  // Checksum, second byte flag, PM words and trailer.
  always_ff @(posedge clk) begin
    if (beat) begin
      if (!collecting) begin
        if (data == START_BYTE) begin
          csum      <= WORD_W'(START_BYTE);
          second_ok <= 1'b0;
          words     <= '0;
          trail_hi  <= '0;
        end
      end else begin
        if (pos == '0) begin
          second_ok <= (data == SECOND_BYTE);
        end
        if (pos < POSW'(FRAME_BYTES - 2)) begin
          csum <= csum + WORD_W'(data);
        end else begin
          trail_hi <= data;
        end
        // PM words are frame bytes three to eight, high byte first.
        for (int w = 0; w < CHANNELS; w++) begin
          if (pos == POSW'(3 + 2 * w) || pos == POSW'(4 + 2 * w)) begin
            words[w] <= {words[w][7:0], data};
          end
        end
        if (last) begin
          frame_pm <= words;
        end
      end
    end
  end

endmodule : psfa_frame
`default_nettype wire

@@ rtl/particle_sensor_frame_averager_unit.sv @@
`default_nettype none
// Sequence: the parser registers a pulse for a good frame's last byte; the window
//   is then read and written once per channel, the divider runs once per channel on
//   SUMW = 16 + clog2(WINDOW) bit sums and the output state registers the result.
// Throughput: one byte per cycle while idle; after a good frame the input is held
//   off through the sequence, longer while the result beat waits to be taken.
// Reset: synchronous; clears parser, slot, fill count and sums, not the sample RAM.
// ----------------------------------------------------------------------------
// particle_sensor_frame_averager_unit
// Decodes particulate sensor frames and keeps a running window of the last
// WINDOW PM1.0, PM2.5 and PM10 samples in one RAM, emitting raw values and
// floor averages for every good frame.
// ----------------------------------------------------------------------------
module particle_sensor_frame_averager_unit
  import psfa_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF,
  parameter int WINDOW      = WINDOW_DEF
) (
  input  wire logic     clk,
  input  wire logic     rst,
  psfa_byte_if.sink     rx,
  psfa_result_if.source result
);

  localparam int SUMW  = WORD_W + $clog2(WINDOW);
  localparam int FCW   = $clog2(WINDOW + 1);
  localparam int SLOTW = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int DEPTH = CHANNELS * WINDOW;
  localparam int ADDRW = $clog2(DEPTH);

  typedef enum logic [5:0] {
    S_IDLE    = 6'b000001,
    S_READ    = 6'b000010,
    S_UPDATE  = 6'b000100,
    S_DIV     = 6'b001000,
    S_DIVWAIT = 6'b010000,
    S_OUT     = 6'b100000
  } state_t;

  state_t                          state;
  state_t                          state_next;
  logic [1:0]                      ch;
  logic [SLOTW-1:0]                slot;
  logic [FCW-1:0]                  fill_count;
  logic                            full;
  logic [CHANNELS-1:0][SUMW-1:0]   sums;
  logic [CHANNELS-1:0][WORD_W-1:0] vals;
  logic [CHANNELS-1:0][WORD_W-1:0] avgs;
  frame_t                          frame;
  logic [ADDRW-1:0]                ch_base;
  logic [ADDRW-1:0]                addr;
  word_t                           old_sample;
  logic                            div_start;
  logic [SUMW-1:0]                 quotient;
  div_status_t                     div_status;
  logic [FCW+HELD_W-1:0]           held_ext;
  logic                            accept;
  logic                            out_free;

  assign accept   = rx.valid && rx.ready;
  assign rx.ready = (state == S_IDLE);
  assign out_free = !result.valid || result.ready;
  assign full     = (fill_count == FCW'(WINDOW));

  // Frame parser.
  psfa_frame #(
    .FRAME_BYTES(FRAME_BYTES)
  ) u_frame (
    .clk  (clk),
    .rst  (rst),
    .beat (accept),
    .data (rx.rx_byte),
    .frame(frame)
  );

  // Ring address: channel block plus the current write slot.
  always_comb begin
    case (ch)
      2'd1:    ch_base = ADDRW'(WINDOW);
      2'd2:    ch_base = ADDRW'(2 * WINDOW);
      default: ch_base = '0;
    endcase
  end
  assign addr = ch_base + ADDRW'(slot);

  // Sample ring for all three channels.
  psfa_ram #(
    .WIDTH(WORD_W),
    .DEPTH(DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (state == S_UPDATE),
    .waddr(addr),
    .wdata(vals[ch]),
    .re   (state == S_READ),
    .raddr(addr),
    .rdata(old_sample)
  );

  // Shared divider for the three averages.
  assign div_start = (state == S_DIV);

  psfa_div #(
    .W (SUMW),
    .DW(FCW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(sums[ch]),
    .divisor (fill_count),
    .quotient(quotient),
    .status  (div_status)
  );

  // Frame-end sequencer.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:    if (frame.valid) state_next = S_READ;
      S_READ:    state_next = S_UPDATE;
      S_UPDATE:  state_next = (ch == CH_LAST) ? S_DIV : S_READ;
      S_DIV:     state_next = S_DIVWAIT;
      S_DIVWAIT: begin
        if (div_status.done) begin
          state_next = (ch == CH_LAST) ? S_OUT : S_DIV;
        end
      end
      S_OUT:     if (out_free) state_next = S_IDLE;
      default:   state_next = S_IDLE;
    endcase
  end

  // Window state: channel index, slot, fill count and running sums.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ch         <= '0;
      slot       <= '0;
      fill_count <= '0;
      sums       <= '0;
    end else begin
      state <= state_next;
      if (state == S_UPDATE) begin
        sums[ch] <= sums[ch] - (full ? SUMW'(old_sample) : SUMW'(0)) + SUMW'(vals[ch]);
        if (ch == CH_LAST) begin
          ch <= '0;
          if (!full) begin
            fill_count <= fill_count + 1'b1;
          end
          slot <= (slot == SLOTW'(WINDOW - 1)) ? '0 : slot + 1'b1;
        end else begin
          ch <= ch + 1'b1;
        end
      end else if (state == S_DIVWAIT && div_status.done) begin
        ch <= (ch == CH_LAST) ? '0 : ch + 1'b1;
      end
    end
  end

  // Frame samples and averages.
  always_ff @(posedge clk) begin
    if (state == S_IDLE && frame.valid) begin
      vals <= frame.pm;
    end
    if (state == S_DIVWAIT && div_status.done) begin
      avgs[ch] <= quotient[WORD_W-1:0];
    end
  end

  assign held_ext = {{HELD_W{1'b0}}, fill_count};

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      result.valid <= 1'b0;
    end else if (state == S_OUT && out_free) begin
      result.valid <= 1'b1;
    end else if (result.ready) begin
      result.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_OUT && out_free) begin
      result.pm1_raw      <= vals[0];
      result.pm25_raw     <= vals[1];
      result.pm10_raw     <= vals[2];
      result.pm1_average  <= avgs[0];
      result.pm25_average <= avgs[1];
      result.pm10_average <= avgs[2];
      result.samples_held <= held_ext[HELD_W-1:0];
    end
  end

  // The window never holds more than WINDOW samples.
  assert property (@(posedge clk) disable iff (rst) fill_count <= FCW'(WINDOW))
    else $error("fill count exceeds window");

  // A new good frame can only complete while the sequencer is idle.
  assert property (@(posedge clk) disable iff (rst) frame.valid |-> state == S_IDLE)
    else $error("frame completed during frame-end sequence");

  // The divider is never restarted while it is still working.
  assert property (@(posedge clk) disable iff (rst) div_start |-> !div_status.busy)
    else $error("divider started while busy");

  // A result beat appears only out of the output state.
  assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(state == S_OUT))
    else $error("result raised outside output state");

  // The write slot stays inside the window.
  assert property (@(posedge clk) disable iff (rst) slot <= SLOTW'(WINDOW - 1))
    else $error("write slot out of range");

endmodule : particle_sensor_frame_averager_unit
`default_nettype wire

@@ sim/tb.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the particle sensor frame averager. Serial bytes
// are pushed through the input channel with random gaps, and the result
// channel is drained with random back-pressure. A frame decoder and window
// averager kept in the bench predicts all untyped readings; each reading beat is
// compared field by field against the oldest prediction. A short table of
// hand-picked frames runs first, followed by mostly well-formed random
// frames mixed with noise and corrupted frames.
// ----------------------------------------------------------------------------
module tb;
  import psfa_pkg::*;

  localparam int FRAME_LEN    = FRAME_BYTES_DEF;
  localparam int WIN          = WINDOW_DEF;
  localparam int BYTE_TARGET  = 1700;
  localparam int MIN_READINGS = 40;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 400000;

  // One reading as the block reports it; channel 0 is PM1.0.
  typedef struct packed {
    word_t [CHANNELS-1:0] raw;
    word_t [CHANNELS-1:0] avg;
    logic [HELD_W-1:0]    held;
  } reading_t;

  typedef enum logic [2:0] {
    FR_GOOD,
    FR_BAD_SECOND,
    FR_BAD_SUM,
    FR_START_INSIDE,
    FR_NOISE
  } frame_kind_e;

  typedef struct packed {
    frame_kind_e kind;
    word_t       pm1;
    word_t       pm25;
    word_t       pm10;
    logic        typed;
    reading_t    want;
  } frame_row_t;

  logic clk;
  logic rst;
  int   cycle_count;
  int   mismatch_count;
  int   bytes_sent;
  int   readings_predicted;
  bit   no_idle;

  psfa_byte_if   rx_chan ();
  psfa_result_if res_chan ();

  particle_sensor_frame_averager_unit #(
    .FRAME_BYTES(FRAME_LEN),
    .WINDOW     (WIN)
  ) i_dut (
    .clk   (clk),
    .rst   (rst),
    .rx    (rx_chan),
    .result(res_chan)
  );

  // Frame parser and window state of the predictor.
  bit          in_frame;
  int unsigned frame_pos;
  int unsigned frame_sum;
  bit          second_ok;
  word_t       pm_word [CHANNELS];
  word_t       trailer_word;
  word_t       hist [CHANNELS][WIN];
  int unsigned hist_sum [CHANNELS];
  int          hist_slot;
  int          hist_fill;

  reading_t pending_readings [$];

  // Directed frames. Typed readings are the ones that follow directly from
  // reset: a first frame at full scale and a second one at zero.
  frame_row_t directed_rows [10] = '{
    '{FR_NOISE,        16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    '{FR_GOOD,         16'hffff, 16'hffff, 16'hffff, 1'b1,
      '{{3{16'hffff}}, {3{16'hffff}}, 5'd1}},
    '{FR_BAD_SUM,      16'h1111, 16'h2222, 16'h3333, 1'b0, '0},
    '{FR_GOOD,         16'h0000, 16'h0000, 16'h0000, 1'b1,
      '{{3{16'h0000}}, {3{16'h7fff}}, 5'd2}},
    '{FR_BAD_SECOND,   16'h4444, 16'h5555, 16'h6666, 1'b0, '0},
    '{FR_START_INSIDE, 16'h4242, 16'h0042, 16'h4200, 1'b0, '0},
    '{FR_NOISE,        16'h0000, 16'h0000, 16'h0000, 1'b0, '0},
    '{FR_GOOD,         16'h1234, 16'habcd, 16'h8000, 1'b0, '0},
    '{FR_BAD_SUM,      16'hffff, 16'h0000, 16'h0001, 1'b0, '0},
    '{FR_GOOD,         16'h0001, 16'hfffe, 16'h7fff, 1'b0, '0}
  };

  // Clock with a period of two time units.
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // Run limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  // Result back-pressure: ready is withheld at random, with a chance of about 18 percent, outside calm stretches.
  always @(posedge clk) begin
    res_chan.ready <= !rst && (no_idle || $urandom_range(99) >= 18);
  end

  // Push one sample set into the averaging windows and form the reading.
  function automatic reading_t window_push();
    reading_t r;
    for (int c = 0; c < CHANNELS; c++) begin
      if (hist_fill >= WIN) begin
        hist_sum[c] -= hist[c][hist_slot];
      end
      hist[c][hist_slot] = pm_word[c];
      hist_sum[c] += pm_word[c];
    end
    if (hist_fill < WIN) begin
      hist_fill++;
    end
    hist_slot = (hist_slot + 1) % WIN;
    for (int c = 0; c < CHANNELS; c++) begin
      r.raw[c] = pm_word[c];
      r.avg[c] = word_t'(hist_sum[c] / hist_fill);
    end
    r.held = hist_fill[HELD_W-1:0];
    return r;
  endfunction

  // Advance the frame parser by one accepted byte; queue a reading when a
  // good frame completes and emit is set.
  function automatic void frame_decode_step(input logic [7:0] b, input bit emit);
    reading_t r;
    if (!in_frame) begin
      if (b == START_BYTE) begin
        in_frame     = 1'b1;
        frame_pos    = 0;
        frame_sum    = START_BYTE;
        second_ok    = 1'b0;
        trailer_word = '0;
        for (int c = 0; c < CHANNELS; c++) begin
          pm_word[c] = '0;
        end
      end
      return;
    end
    if (frame_pos == 0) begin
      second_ok = (b == SECOND_BYTE);
    end
    if (frame_pos < FRAME_LEN - 2) begin
      frame_sum += b;
    end
    if (frame_pos >= 3 && frame_pos <= 8) begin
      pm_word[(frame_pos - 3) / 2] = {pm_word[(frame_pos - 3) / 2][7:0], b};
    end
    if (frame_pos >= FRAME_LEN - 2) begin
      trailer_word = {trailer_word[7:0], b};
    end
    if (frame_pos + 1 < FRAME_LEN) begin
      frame_pos++;
      return;
    end
    in_frame  = 1'b0;
    frame_pos = 0;
    if (second_ok && frame_sum[15:0] == trailer_word && frame_sum <= 32'hffff) begin
      r = window_push();
      readings_predicted++;
      if (emit) begin
        pending_readings.push_back(r);
      end
    end
  endfunction

  // Present one byte, with a random gap in front, and wait for its beat.
  task automatic put_byte(input logic [7:0] b, input bit emit);
    while (!no_idle && $urandom_range(99) < 18) begin
      rx_chan.valid <= 1'b0;
      @(posedge clk);
    end
    rx_chan.valid   <= 1'b1;
    rx_chan.rx_byte <= b;
    @(posedge clk);
    while (!rx_chan.ready) begin
      @(posedge clk);
    end
    bytes_sent++;
    frame_decode_step(b, emit);
  endtask

  // Bytes sent while the parser hunts; a start byte only if allowed.
  task automatic send_noise(input int count, input bit allow_start);
    logic [7:0] b;
    for (int i = 0; i < count; i++) begin
      b = 8'($urandom_range(255));
      while (!allow_start && b == START_BYTE) begin
        b = 8'($urandom_range(255));
      end
      put_byte(b, 1'b1);
    end
  endtask

  // Build and send one frame. start_pct is the chance of a start byte in
  // each filler position.
  task automatic send_frame(input frame_kind_e kind, input word_t pm1,
                            input word_t pm25, input word_t pm10,
                            input int start_pct, input bit emit);
    logic [7:0]  fb [FRAME_LEN];
    int unsigned sum;
    word_t       trailer;
    fb[0] = SECOND_BYTE;
    if (kind == FR_BAD_SECOND) begin
      while (fb[0] == SECOND_BYTE) begin
        fb[0] = 8'($urandom_range(255));
      end
    end
    fb[1] = 8'($urandom_range(255));
    fb[2] = 8'($urandom_range(255));
    {fb[3], fb[4]} = pm1;
    {fb[5], fb[6]} = pm25;
    {fb[7], fb[8]} = pm10;
    for (int i = 9; i < FRAME_LEN - 2; i++) begin
      fb[i] = ($urandom_range(99) < start_pct) ? START_BYTE : 8'($urandom_range(255));
    end
    sum = START_BYTE;
    for (int i = 0; i < FRAME_LEN - 2; i++) begin
      sum += fb[i];
    end
    trailer = sum[15:0];
    if (kind == FR_BAD_SUM) begin
      trailer ^= 16'($urandom_range(65535, 1));
    end
    {fb[FRAME_LEN-2], fb[FRAME_LEN-1]} = trailer;
    put_byte(START_BYTE, emit);
    for (int i = 0; i < FRAME_LEN; i++) begin
      put_byte(fb[i], emit);
    end
  endtask

  // PM word with weight on the extremes and on low readings.
  function automatic word_t pick_word();
    int sel;
    sel = $urandom_range(99);
    if (sel < 10) begin
      return 16'h0000;
    end else if (sel < 20) begin
      return 16'hffff;
    end else if (sel < 50) begin
      return word_t'($urandom_range(300));
    end
    return word_t'($urandom_range(65535));
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
      mismatch_count++;
    end
  endfunction

  // Compare every reading beat against the oldest prediction.
  always @(posedge clk) begin
    reading_t seen;
    reading_t want;
    if (!rst && res_chan.valid && res_chan.ready) begin
      seen.raw  = {res_chan.pm10_raw, res_chan.pm25_raw, res_chan.pm1_raw};
      seen.avg  = {res_chan.pm10_average, res_chan.pm25_average, res_chan.pm1_average};
      seen.held = res_chan.samples_held;
      if (pending_readings.size() == 0) begin
        $display("%0t: unexpected reading: expected none, actual %h", $time, seen);
        mismatch_count++;
      end else begin
        want = pending_readings.pop_front();
        check_field("pm1_raw", want.raw[0], seen.raw[0]);
        check_field("pm25_raw", want.raw[1], seen.raw[1]);
        check_field("pm10_raw", want.raw[2], seen.raw[2]);
        check_field("pm1_average", want.avg[0], seen.avg[0]);
        check_field("pm25_average", want.avg[1], seen.avg[1]);
        check_field("pm10_average", want.avg[2], seen.avg[2]);
        check_field("samples_held", want.held, seen.held);
      end
    end
  end

  // Stimulus: reset, directed frames, random frames, drain.
  initial begin
    int          frame_idx;
    int          sel;
    frame_kind_e kind;
    rst                = 1'b1;
    rx_chan.valid      = 1'b0;
    rx_chan.rx_byte    = '0;
    res_chan.ready     = 1'b0;
    cycle_count        = 0;
    mismatch_count     = 0;
    bytes_sent         = 0;
    readings_predicted = 0;
    no_idle            = 1'b0;
    in_frame           = 1'b0;
    frame_pos          = 0;
    frame_sum          = 0;
    second_ok          = 1'b0;
    trailer_word       = '0;
    hist_slot          = 0;
    hist_fill          = 0;
    for (int c = 0; c < CHANNELS; c++) begin
      hist_sum[c] = 0;
      pm_word[c]  = '0;
    end
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // Directed table.
    foreach (directed_rows[i]) begin
      if (directed_rows[i].kind == FR_NOISE) begin
        send_noise(6, 1'b0);
      end else begin
        send_frame(directed_rows[i].kind, directed_rows[i].pm1, directed_rows[i].pm25,
                   directed_rows[i].pm10,
                   (directed_rows[i].kind == FR_START_INSIDE) ? 100 : 0,
                   !directed_rows[i].typed);
        if (directed_rows[i].typed) begin
          pending_readings.push_back(directed_rows[i].want);
        end
      end
    end

    // Random frames, with one long calm stretch in the middle.
    frame_idx = 0;
    while (bytes_sent < BYTE_TARGET || readings_predicted < MIN_READINGS) begin
      no_idle = (frame_idx >= 15 && frame_idx < 30);
      sel = $urandom_range(99);
      if (sel < 8) begin
        send_noise($urandom_range(6, 1), $urandom_range(7) == 0);
      end else begin
        if (sel < 14) begin
          kind = FR_BAD_SECOND;
        end else if (sel < 22) begin
          kind = FR_BAD_SUM;
        end else begin
          kind = FR_GOOD;
        end
        send_frame(kind, pick_word(), pick_word(), pick_word(), 10, 1'b1);
      end
      frame_idx++;
    end
    no_idle = 1'b0;
    rx_chan.valid <= 1'b0;

    // Drain outstanding readings, then watch for stray beats.
    while (pending_readings.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule : tb
`default_nettype wire

@@ sim.f @@
rtl/psfa_pkg.sv
rtl/psfa_if.sv
rtl/psfa_ram.sv
rtl/psfa_div.sv
rtl/psfa_frame.sv
rtl/particle_sensor_frame_averager_unit.sv
sim/tb.sv
